// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and control/status bundles of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 12;            // 9 * 255
  localparam int NUM_W      = 4;             // up to 9 neighbors
  localparam int DVD_W      = SUM_W + 1;     // 2*sum + n
  localparam int DVS_W      = NUM_W + 1;     // 2*n
  localparam int REM_W      = DVD_W - CH_W;
  localparam int DIV_STEPS  = CH_W;
  localparam int STEP_W     = 4;
  localparam int WREG_W     = 11;
  localparam int ROW_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // Which result is being built
  typedef enum logic [1:0] {
    KIND_MAIN  = 2'd0,   // centered one column left of the newest pixel
    KIND_EDGE  = 2'd1,   // right-edge result at the end of a row
    KIND_DRAIN = 2'd2    // last-row result from the line buffers
  } kind_t;

  typedef struct packed {
    logic  pix_start;
    logic  pix_shift;
    logic  drain_start;
    logic  drain_rd;
    logic  acc_start;
    logic  acc_add;
    logic  j_inc;
    logic  div_load;
    logic  div_step;
    logic  out_load;
    logic  drain_adv;
    kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic drain_ok;
    logic res_main;
    logic res_edge;
    logic res2_pend;
    logic j_last;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/box_blur_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Edge-aware 3x3 box blur over a raster RGB stream with two line buffers.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. A pixel that causes no result is done once
// the window has shifted; each result it causes is built in steps: accumulate
// the three window columns, load the divider, run the divide steps, then load
// the output register once it is free. A drain reads the three line buffer
// columns one at a time, each read followed by its accumulate step. Results
// come from the column-at-a-time accumulator and the one-bit-per-cycle divider
// computing (2*sum+n)/(2n). The line buffers are two banks of MAX_WIDTH pixels
// with one read and one write port each; they need no clearing after reset. A
// finished result waits in the output register while the next transaction is taken.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red_in, green_in, blue_in
  input  logic [0:0]  in_tuser,    // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // red_out, green_out, blue_out
  output logic        out_tlast    // frame_last
);
  import bblur_pkg::*;

  `include "assert_macros.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      pix_load;

  bblur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  bblur_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign pix_load = cmd.out_load && (cmd.kind != KIND_DRAIN);

  `ASSERT_IMPLY(a_out_load_free, clk, rst_n, cmd.out_load, !out_tvalid || out_tready, "overrun")
  `ASSERT_NEXT(a_div_busy, clk, rst_n, cmd.div_load, !sts.div_done, "divider done early")
  `ASSERT_NEXT(a_pix_no_last, clk, rst_n, pix_load, !out_tlast, "pixel result marked last")

endmodule

// ===== sv/bblur_ctrl.sv =====
// ----------------------------------------------------------------------------
// bblur_ctrl
// Sequencer: accepts transactions and steps the datapath through each result.
// ----------------------------------------------------------------------------
module bblur_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,
  input  bblur_pkg::ctrl_sts_t  sts,
  output bblur_pkg::ctrl_cmd_t  cmd
);
  import bblur_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PSHIFT = 8'b0000_0010,
    S_ACC    = 8'b0000_0100,
    S_DRD    = 8'b0000_1000,
    S_DACC   = 8'b0001_0000,
    S_DIVL   = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_comb begin
    cmd       = '0;
    cmd.kind  = kind_r;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == CMD_DRAIN) begin
            if (sts.drain_ok) begin
              cmd.drain_start = 1'b1;
              cmd.acc_start   = 1'b1;
              kind_nxt        = KIND_DRAIN;
              state_nxt       = S_DRD;
            end
          end else if (sts.pix_ok) begin
            cmd.pix_start = 1'b1;
            state_nxt     = S_PSHIFT;
          end
        end
      end
      S_PSHIFT: begin
        cmd.pix_shift = 1'b1;
        if (sts.res_main) begin
          cmd.acc_start = 1'b1;
          kind_nxt      = KIND_MAIN;
          state_nxt     = S_ACC;
        end else if (sts.res_edge) begin
          cmd.acc_start = 1'b1;
          kind_nxt      = KIND_EDGE;
          state_nxt     = S_ACC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (sts.j_last) begin
          state_nxt = S_DIVL;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      S_DRD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = S_DACC;
      end
      S_DACC: begin
        cmd.acc_add = 1'b1;
        if (sts.j_last) begin
          state_nxt = S_DIVL;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          if (kind_r == KIND_DRAIN) begin
            cmd.drain_adv = 1'b1;
          end else if ((kind_r == KIND_MAIN) && sts.res2_pend) begin
            cmd.acc_start = 1'b1;
            kind_nxt      = KIND_EDGE;
            state_nxt     = S_ACC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_MAIN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// ===== sv/bblur_div.sv =====
// ----------------------------------------------------------------------------
// bblur_div
// Bit-serial restoring divider, three color lanes sharing one divisor:
// q = (2*sum + n) / (2*n), one quotient bit per step.
// ----------------------------------------------------------------------------
module bblur_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic                                   step,
  input  logic [2:0][bblur_pkg::SUM_W-1:0]       sum_i,
  input  logic [bblur_pkg::NUM_W-1:0]            num_i,
  output logic [2:0][bblur_pkg::CH_W-1:0]        quo_o,
  output logic                                   done_o
);
  import bblur_pkg::*;

  logic [DVS_W-1:0]            dvs_r;
  logic [2:0][REM_W-1:0]       rem_r;
  logic [2:0][CH_W-1:0]        lowq_r;
  logic [STEP_W-1:0]           cnt_r;

  logic [NUM_W-1:0]            num_eff;
  logic [2:0][DVD_W-1:0]       dvd;
  logic [2:0][REM_W:0]         trial;
  logic [2:0]                  qbit;
  logic [2:0][REM_W-1:0]       rem_nxt;

  always_comb begin
    num_eff = (num_i == '0) ? NUM_W'(1) : num_i;
    for (int ch = 0; ch < 3; ch++) begin
      dvd[ch]     = {sum_i[ch], 1'b0} + DVD_W'(num_eff);
      trial[ch]   = {rem_r[ch], lowq_r[ch][CH_W-1]};
      qbit[ch]    = trial[ch] >= (REM_W+1)'(dvs_r);
      rem_nxt[ch] = qbit[ch] ? REM_W'(trial[ch] - (REM_W+1)'(dvs_r))
                             : REM_W'(trial[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvs_r <= {num_eff, 1'b0};
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch]  <= dvd[ch][DVD_W-1:CH_W];
        lowq_r[ch] <= dvd[ch][CH_W-1:0];
      end
    end else if (step) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch]  <= rem_nxt[ch];
        lowq_r[ch] <= {lowq_r[ch][CH_W-2:0], qbit[ch]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + STEP_W'(1);
    end
  end

  assign done_o = (cnt_r == STEP_W'(DIV_STEPS));
  assign quo_o  = lowq_r;

endmodule

// ===== sv/bblur_dp.sv =====
// ----------------------------------------------------------------------------
// bblur_dp
// Datapath: config registers, position counters, two line buffer banks,
// 3x3 window, column-wise accumulator, divider and output register.
// ----------------------------------------------------------------------------
module bblur_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bblur_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bblur_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [bblur_pkg::PIX_W-1:0]          in_tdata,
  input  bblur_pkg::ctrl_cmd_t                 cmd,
  output bblur_pkg::ctrl_sts_t                 sts,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [bblur_pkg::PIX_W-1:0]          out_tdata,
  output logic                                 out_tlast
);
  import bblur_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = CW + 1;

  typedef logic [2:0][PIX_W-1:0] wcol_t;   // rows top, middle, newest

  logic [WREG_W-1:0] width_r;
  logic [ROW_W-1:0]  height_r;
  logic [ROW_W-1:0]  row_r;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     drn_r;
  logic [CW-1:0]     k_r;
  logic              last_r;
  logic              left1_r, left2_r, top_r, res2_r;
  logic [1:0]        j_r;
  pix_t              pix_r;
  pix_t              rd0_r, rd1_r;
  wcol_t             win_r [3];
  logic [2:0][SUM_W-1:0] acc_r;
  logic [NUM_W-1:0]  accn_r;
  logic              out_tvalid_r;
  pix_t              out_data_r;
  logic              out_last_r;

  pix_t              bank0 [MAX_WIDTH];
  pix_t              bank1 [MAX_WIDTH];

  logic [WW-1:0]     w_eff;
  logic [CW-1:0]     wm1;
  logic [ROW_W-1:0]  h_eff;
  logic              row_end, c_ge1, c_ge2, r_ge1, r_ge2, h_ge2, bslot, drain_last;
  logic [CW-1:0]     k_nxt, dcol, mem_addr;
  logic              mem_rd;
  pix_t              top_pix, mid_pix;
  wcol_t             win_sel;
  wcol_t             src;
  logic [2:0]        src_mask;
  logic              src_ok;
  logic [2:0][SUM_W-1:0] add_sum;
  logic [2:0][CH_W-1:0]  quo;
  logic              div_done;

  // Effective geometry
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    wm1        = CW'(w_eff - WW'(1));
    h_eff      = (height_r == '0) ? ROW_W'(1) : height_r;
    row_end    = col_r >= wm1;
    c_ge1      = col_r != '0;
    c_ge2      = 32'(col_r) >= 32'd2;
    r_ge1      = row_r != '0;
    r_ge2      = row_r >= ROW_W'(2);
    h_ge2      = h_eff >= ROW_W'(2);
    bslot      = ~h_eff[0];
    drain_last = drn_r >= wm1;
    k_nxt      = drain_last ? wm1 : drn_r;
    dcol       = CW'(k_r + CW'(j_r) - CW'(1));
    mem_rd     = cmd.pix_start | cmd.drain_rd;
    mem_addr   = cmd.drain_rd ? dcol : col_r;
    top_pix    = row_r[0] ? rd1_r : rd0_r;
    mid_pix    = row_r[0] ? rd0_r : rd1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WREG_W'(1);
      height_r <= ROW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
      endcase
    end
  end

  // Line buffer banks, read-before-write
  always_ff @(posedge clk) begin
    if (cmd.pix_start && !row_r[0]) begin
      bank0[col_r] <= in_tdata;
    end
    if (mem_rd) begin
      rd0_r <= bank0[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_start && row_r[0]) begin
      bank1[col_r] <= in_tdata;
    end
    if (mem_rd) begin
      rd1_r <= bank1[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_start) begin
      pix_r <= in_tdata;
    end
    if (cmd.pix_shift) begin
      left1_r <= c_ge2;
      left2_r <= c_ge1;
      top_r   <= r_ge2;
      res2_r  <= r_ge1 & row_end;
    end
    if (cmd.drain_start) begin
      k_r    <= k_nxt;
      last_r <= drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.pix_shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= {pix_r, mid_pix, top_pix};
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      drn_r <= '0;
    end else if (cmd.pix_shift) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end else if (cmd.drain_adv) begin
      if (last_r) begin
        row_r <= '0;
        col_r <= '0;
        drn_r <= '0;
      end else begin
        drn_r <= drn_r + CW'(1);
      end
    end
  end

  // Column source for the accumulator
  always_comb begin
    case (j_r)
      2'd0:    win_sel = win_r[0];
      2'd1:    win_sel = win_r[1];
      default: win_sel = win_r[2];
    endcase
    src      = win_sel;
    src_mask = {2'b11, top_r};
    case (cmd.kind)
      KIND_MAIN: src_ok = (j_r != 2'd0) || left1_r;
      KIND_EDGE: src_ok = (j_r == 2'd2) || ((j_r == 2'd1) && left2_r);
      KIND_DRAIN: begin
        src      = {{PIX_W{1'b0}}, (bslot ? rd0_r : rd1_r), (bslot ? rd1_r : rd0_r)};
        src_mask = {1'b0, h_ge2, 1'b1};
        case (j_r)
          2'd0:    src_ok = k_r != '0;
          2'd1:    src_ok = 1'b1;
          default: src_ok = k_r < wm1;
        endcase
      end
      default: src_ok = 1'b0;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      add_sum[ch] = acc_r[ch];
      for (int rw = 0; rw < 3; rw++) begin
        if (src_mask[rw]) begin
          add_sum[ch] = add_sum[ch] + SUM_W'(src[rw][ch*CH_W +: CH_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (cmd.acc_start) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      acc_r  <= '0;
      accn_r <= '0;
    end else if (cmd.acc_add && src_ok) begin
      acc_r  <= add_sum;
      accn_r <= accn_r + NUM_W'($countones(src_mask));
    end
  end

  bblur_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (cmd.div_load),
    .step   (cmd.div_step),
    .sum_i  (acc_r),
    .num_i  (accn_r),
    .quo_o  (quo),
    .done_o (div_done)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {quo[2], quo[1], quo[0]};
      out_last_r <= (cmd.kind == KIND_DRAIN) && last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.pix_ok    = row_r < h_eff;
    sts.drain_ok  = row_r >= h_eff;
    sts.res_main  = r_ge1 & c_ge1;
    sts.res_edge  = r_ge1 & row_end;
    sts.res2_pend = res2_r;
    sts.j_last    = j_r == 2'd2;
    sts.div_done  = div_done;
    sts.out_free  = !out_tvalid_r || out_tready;
  end

endmodule

// ===== dv/tb_box_blur_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware
// Self-checking bench for the edge-aware 3x3 box blur. A directed table covers
// reset defaults, ignored commands, degenerate and oversized register values
// and a mid-image shrink. Random images of many sizes follow, with noise
// commands and mid-image register changes. Typed table rows carry their expected
// results, an in-bench model predicts the rest; each output is checked in order.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware;
  timeunit 1ns;
  timeprecision 1ps;

  import bblur_pkg::*;

  localparam int          MAXW        = 1024;
  localparam int          SETTLE_CYC  = 40;
  localparam int          HOLD_CYC    = 300;
  localparam int          RAND_ITEMS  = 1850;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // red in the low byte, so literals read 24'hBBGGRR
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  typedef struct packed {
    rgb_t px;
    logic last;
  } blur_res_t;

  typedef struct {
    int unsigned r, g, b, n;
  } sum_t;

  typedef enum logic [1:0] {STEP_PIX, STEP_DRAIN, STEP_CFG} step_e;

  typedef struct packed {
    step_e       op;
    rgb_t        px;
    logic [15:0] w_word;
    logic [15:0] h_word;
    bit          typed;
    bit          has_res;
    rgb_t        res_px;
    logic        res_last;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tlast;

  // blur model state
  rgb_t        line_mem [2][MAXW];
  rgb_t        win [9];
  int unsigned row_cnt, col_cnt, drain_cnt;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  blur_res_t   blur_q [$];

  int unsigned fail_cnt = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  bit          streaming = 1'b0;

  dir_row_t dir_tab [30] = '{
    // reset geometry 1x1: early drain, pixel, late pixel, final drain
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h8000FF, 16'h0000, 16'h0000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h563412, 16'h0000, 16'h0000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b1, 1'b1, 24'h8000FF, 1'b1},
    // zero width and height act as one
    '{STEP_CFG,   24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFFFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b1, 1'b1, 24'hFFFFFF, 1'b1},
    // 3x3 image with corners, edges and center
    '{STEP_CFG,   24'h000000, 16'h0003, 16'h0003, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h0000FF, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h00FF00, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFF0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h808080, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h7F7F7F, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    // oversized width and maximum height, then shrunk mid-image
    '{STEP_CFG,   24'h000000, 16'h07FF, 16'hFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h123456, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hEDCBA9, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h55AA55, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_CFG,   24'h000000, 16'h0002, 16'h0002, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hAA55AA, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'h010203, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_PIX,   24'hFEFDFC, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{STEP_DRAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h000000, 1'b0}
  };

  box_blur_3x3_edge_aware #(.MAX_WIDTH(MAXW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic sum_t sum_add(sum_t s, rgb_t p);
    s.r += p.r;
    s.g += p.g;
    s.b += p.b;
    s.n += 1;
    return s;
  endfunction

  // round-half-up mean: (2*sum + n) / (2*n)
  function automatic rgb_t sum_mean(sum_t s);
    rgb_t        p;
    int unsigned n;
    n = (s.n == 0) ? 1 : s.n;
    p.r = 8'((2 * s.r + n) / (2 * n));
    p.g = 8'((2 * s.g + n) / (2 * n));
    p.b = 8'((2 * s.b + n) / (2 * n));
    return p;
  endfunction

  // mean around window column k of the middle row, out-of-image taps masked
  function automatic rgb_t window_mean(int k, bit left_ok, bit right_ok, bit top_ok);
    sum_t s;
    s = '{0, 0, 0, 0};
    for (int row = 0; row < 3; row++) begin
      if (row == 0 && !top_ok) continue;
      for (int col = k - 1; col <= k + 1; col++) begin
        if (col < 0 || col > 2) continue;
        if (col == k - 1 && !left_ok) continue;
        if (col == k + 1 && !right_ok) continue;
        s = sum_add(s, win[row * 3 + col]);
      end
    end
    return sum_mean(s);
  endfunction

  function automatic logic [15:0] width_word(int unsigned w);
    return {5'($urandom_range(0, 31)), 11'(w)};
  endfunction

  // advances the blur model by one accepted transaction
  task automatic blur_apply(input logic cmd, input rgb_t px, input bit keep,
                            output bit acted, output bit closed);
    int unsigned w, h, c, slot, d, k, bslot;
    bit          row_end, fin;
    rgb_t        top, mid;
    sum_t        s;
    w = eff_w();
    h = eff_h();
    acted = 1'b0;
    closed = 1'b0;
    if (cmd == CMD_PIXEL) begin
      if (row_cnt >= h) return;
      acted = 1'b1;
      c = (col_cnt >= MAXW) ? MAXW - 1 : col_cnt;
      slot = row_cnt & 1;
      top = line_mem[slot][c];
      mid = line_mem[slot ^ 1][c];
      for (int i = 0; i < 3; i++) begin
        win[i * 3]     = win[i * 3 + 1];
        win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      line_mem[slot][c] = px;
      row_end = (c >= w - 1);
      if (row_cnt >= 1 && keep) begin
        if (c >= 1) blur_q.push_back('{window_mean(1, c >= 2, 1'b1, row_cnt >= 2), 1'b0});
        if (row_end) blur_q.push_back('{window_mean(2, c >= 1, 1'b0, row_cnt >= 2), 1'b0});
      end
      if (row_end) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) & 16'hFFFF;
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      if (row_cnt < h) return;
      acted = 1'b1;
      d = drain_cnt;
      fin = (d >= w - 1);
      k = fin ? w - 1 : d;
      bslot = (h - 1) & 1;
      s = '{0, 0, 0, 0};
      for (int col = (k == 0) ? 0 : int'(k) - 1; col <= int'(k) + 1 && col < int'(w);
           col++) begin
        s = sum_add(s, line_mem[bslot][col]);
        if (h >= 2) s = sum_add(s, line_mem[bslot ^ 1][col]);
      end
      if (keep) blur_q.push_back('{sum_mean(s), fin});
      if (fin) begin
        row_cnt = 0;
        col_cnt = 0;
        drain_cnt = 0;
        closed = 1'b1;
      end else begin
        drain_cnt = d + 1;
      end
    end
  endtask

  task automatic push_item(input logic cmd, input rgb_t px, input bit keep,
                           output bit acted, output bit closed);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    blur_apply(cmd, px, keep, acted, closed);
  endtask

  // block idle: nothing outstanding, then time for a resultless transaction
  task automatic settle();
    in_tvalid <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] w_word, input logic [15:0] h_word);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IMAGE_WIDTH;
    cfg_wdata <= w_word;
    @(posedge clk);
    width_reg = w_word[10:0];
    cfg_addr  <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h_word;
    @(posedge clk);
    height_reg = h_word;
    cfg_we <= 1'b0;
  endtask

  // output checker
  always @(posedge clk) begin : result_check
    blur_res_t want;
    rgb_t      got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (blur_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: r %0d g %0d b %0d last %b",
                   got.r, got.g, got.b, out_tlast);
      end else begin
        want = blur_q.pop_front();
        if (got.r !== want.px.r || got.g !== want.px.g || got.b !== want.px.b ||
            out_tlast !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp r %0d g %0d b %0d last %b, got r %0d g %0d b %0d last %b",
                     want.px.r, want.px.g, want.px.b, want.last,
                     got.r, got.g, got.b, out_tlast);
        end
      end
    end
  end

  // result receiver with random stalls and occasional long hold-off
  initial begin : sink
    int unsigned stall, taken, hold_at;
    taken = 0;
    hold_at = 150;
    while (!rst_n) @(posedge clk);
    forever begin
      if (streaming && in_tvalid && taken >= hold_at) begin
        stall = HOLD_CYC;
        hold_at = taken + 700;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      taken++;
      if (taken % 40 == 0) sink_burst = ($urandom_range(0, 4) == 0);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    bit          acted, closed, want_drain, noise, mid_done;
    int unsigned done_items, w, h, nw, nh;
    logic [15:0] w_word, h_word;
    logic        cmd;
    rgb_t        px;

    foreach (line_mem[s, c]) line_mem[s][c] = '0;
    foreach (win[i]) win[i] = '0;
    row_cnt = 0;
    col_cnt = 0;
    drain_cnt = 0;
    width_reg = 11'd1;
    height_reg = 16'd1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == STEP_CFG) begin
        set_regs(dir_tab[i].w_word, dir_tab[i].h_word);
      end else begin
        cmd = (dir_tab[i].op == STEP_DRAIN) ? CMD_DRAIN : CMD_PIXEL;
        push_item(cmd, dir_tab[i].px, !dir_tab[i].typed, acted, closed);
        if (dir_tab[i].typed && dir_tab[i].has_res)
          blur_q.push_back('{dir_tab[i].res_px, dir_tab[i].res_last});
      end
    end

    streaming = 1'b1;
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
      end
      w_word = width_word((w == 1 && $urandom_range(0, 1)) ? 0 : w);
      h_word = (h == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(h);
      set_regs(w_word, h_word);
      src_burst = ($urandom_range(0, 4) == 0);
      mid_done = 1'b0;
      closed = 1'b0;
      while (!closed) begin
        // shrink width or move height while the image is open
        if (!mid_done && $urandom_range(0, 149) == 0) begin
          mid_done = 1'b1;
          nw = $urandom_range(1, eff_w());
          nh = $urandom_range(1, eff_h() + 2);
          set_regs(width_word(nw), 16'(nh));
        end
        want_drain = (row_cnt >= eff_h());
        noise = ($urandom_range(0, 31) == 0);
        cmd = (want_drain ^ noise) ? CMD_DRAIN : CMD_PIXEL;
        if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        else px = rgb_t'($urandom);
        push_item(cmd, px, 1'b1, acted, closed);
        if (acted) done_items++;
      end
    end
    streaming = 1'b0;

    in_tvalid <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
